// ===== hw/rtl/circumcircle_from_three_points_defines.svh =====
// ----------------------------------------------------------------------------
// circumcircle_from_three_points_defines
// assertion macros for the circumcircle block
// ----------------------------------------------------------------------------
`ifndef CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH
`define CIRCUMCIRCLE_FROM_THREE_POINTS_DEFINES_SVH

// a condition implies another in the same cycle
`define CC_ASSERT_IMP(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lbl failed");

// a condition implies another in the next cycle
`define CC_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lbl failed");

`endif

// ===== hw/rtl/cc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc_pkg
// widths, stage counts and shared types of the circumcircle pipeline
// ----------------------------------------------------------------------------
package cc_pkg;

    localparam int CW    = 16;
    // relative coordinates
    localparam int RW    = CW + 1;
    // products of two relative coordinates
    localparam int PW    = 2 * RW;
    // squared sums
    localparam int SW    = PW + 1;
    // numerators: coord times squared sum, difference
    localparam int NW    = RW + SW + 1;
    // determinant
    localparam int DW    = PW + 2;
    // quotient bits produced by the divider
    localparam int QW    = NW;
    // radius squared input width (from clamped offsets of CW+1 bits)
    localparam int OW    = CW + 2;
    localparam int RSW   = 2 * OW;
    localparam int RRW   = OW;

    // front stages before the divider chain
    localparam int FRONT = 4;

    // per request context carried alongside the cells
    typedef struct packed {
        logic                 vld;
        logic                 degen;
        logic signed [CW-1:0] pax;
        logic signed [CW-1:0] pay;
    } ctx_t;

    // one long division cell payload for both offsets
    typedef struct packed {
        ctx_t              ctx;
        logic              neg_x;
        logic              neg_y;
        logic [NW-1:0]     rem_x;
        logic [NW-1:0]     rem_y;
        logic [NW-1:0]     num_x;
        logic [NW-1:0]     num_y;
        logic [DW-1:0]     den;
        logic [QW-1:0]     q_x;
        logic [QW-1:0]     q_y;
    } div_t;

    // square root cell payload
    typedef struct packed {
        ctx_t              ctx;
        logic signed [CW-1:0] cxs;
        logic signed [CW-1:0] cys;
        logic              ovf;
        logic              big;
        logic [RSW-1:0]    n;
        logic [RSW-1:0]    rem;
        logic [RRW-1:0]    root;
    } sqr_t;

endpackage

// ===== hw/rtl/cc_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc_div_cell
// one restoring division step for both center offsets
// ----------------------------------------------------------------------------
module cc_div_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  cc_pkg::div_t   din,
    output cc_pkg::div_t   dout
);

    cc_pkg::div_t d_next;
    cc_pkg::div_t d_reg;
    logic         vld_reg;
    logic [cc_pkg::NW:0] tx;
    logic [cc_pkg::NW:0] ty;
    logic [cc_pkg::NW:0] den_ext;

    // shift in the next numerator bit, trial subtract
    always_comb
    begin
        d_next  = din;
        den_ext = {{(cc_pkg::NW + 1 - cc_pkg::DW){1'b0}}, din.den};
        tx = {din.rem_x, din.num_x[cc_pkg::NW-1]};
        ty = {din.rem_y, din.num_y[cc_pkg::NW-1]};
        d_next.num_x = {din.num_x[cc_pkg::NW-2:0], 1'b0};
        d_next.num_y = {din.num_y[cc_pkg::NW-2:0], 1'b0};
        if (tx >= den_ext)
        begin
            tx = tx - den_ext;
            d_next.q_x = {din.q_x[cc_pkg::QW-2:0], 1'b1};
        end
        else
        begin
            d_next.q_x = {din.q_x[cc_pkg::QW-2:0], 1'b0};
        end
        if (ty >= den_ext)
        begin
            ty = ty - den_ext;
            d_next.q_y = {din.q_y[cc_pkg::QW-2:0], 1'b1};
        end
        else
        begin
            d_next.q_y = {din.q_y[cc_pkg::QW-2:0], 1'b0};
        end
        d_next.rem_x = tx[cc_pkg::NW-1:0];
        d_next.rem_y = ty[cc_pkg::NW-1:0];
    end

    // payload register
    always_ff @(posedge clk)
    begin
        d_reg <= d_next;
    end

    // valid bit with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= din.ctx.vld;
    end

    always_comb
    begin
        dout = d_reg;
        dout.ctx.vld = vld_reg;
    end

endmodule

// ===== hw/rtl/cc_sqrt_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc_sqrt_cell
// one bit of the floor square root of the squared offset
// ----------------------------------------------------------------------------
module cc_sqrt_cell (
    input  logic           clk,
    input  logic           rst_n,
    input  cc_pkg::sqr_t   din,
    output cc_pkg::sqr_t   dout
);

    cc_pkg::sqr_t s_next;
    cc_pkg::sqr_t s_reg;
    logic         vld_reg;
    logic [cc_pkg::RSW+1:0] trial;
    logic [cc_pkg::RSW+1:0] rem2;

    // bring down two bits, try root*4+1
    always_comb
    begin
        s_next = din;
        rem2   = {din.rem, din.n[cc_pkg::RSW-1:cc_pkg::RSW-2]};
        trial  = {{(cc_pkg::RSW + 2 - cc_pkg::RRW - 2){1'b0}}, din.root, 2'b01};
        s_next.n = {din.n[cc_pkg::RSW-3:0], 2'b00};
        if (rem2 >= trial)
        begin
            rem2        = rem2 - trial;
            s_next.root = {din.root[cc_pkg::RRW-2:0], 1'b1};
        end
        else
        begin
            s_next.root = {din.root[cc_pkg::RRW-2:0], 1'b0};
        end
        s_next.rem = rem2[cc_pkg::RSW-1:0];
    end

    // payload register
    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
    end

    // valid bit with reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= din.ctx.vld;
    end

    always_comb
    begin
        dout = s_reg;
        dout.ctx.vld = vld_reg;
    end

endmodule

// ===== hw/rtl/circumcircle_from_three_points.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// circumcircle_from_three_points
// center and radius of the circle through three Q8.8 points
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  request  | start / busy       | ax ay bx by_coord cx cy
//  result   | done (one cycle)   | center_x center_y radius_out degenerate overflow
//
// one request per cycle; busy is tied low
// result path in order: 4 front stages, NW (53) division cells,
// fixup and squaring registers, 18 root cells, 1 out
// the chain of division cells sets the latency, one quotient bit per cell
// reset clears only valid bits; results cannot be stalled
module circumcircle_from_three_points (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic signed [15:0]        ax,
    input  logic signed [15:0]        ay,
    input  logic signed [15:0]        bx,
    input  logic signed [15:0]        by_coord,
    input  logic signed [15:0]        cx,
    input  logic signed [15:0]        cy,
    output logic                      done,
    output logic signed [15:0]        center_x,
    output logic signed [15:0]        center_y,
    output logic [15:0]               radius_out,
    output logic                      degenerate,
    output logic                      overflow
);
`include "circumcircle_from_three_points_defines.svh"

    localparam int CW  = cc_pkg::CW;
    localparam int RW  = cc_pkg::RW;
    localparam int PW  = cc_pkg::PW;
    localparam int SW  = cc_pkg::SW;
    localparam int NW  = cc_pkg::NW;
    localparam int DW  = cc_pkg::DW;
    localparam int OW  = cc_pkg::OW;
    localparam int RSW = cc_pkg::RSW;
    localparam int NR  = cc_pkg::RRW;

    assign busy = 1'b0;

    // stage 1: relative coordinates
    logic v1_reg;
    logic signed [CW-1:0] pax1_reg, pay1_reg;
    logic signed [RW-1:0] rbx_reg, rby_reg, rcx_reg, rcy_reg;
    always_ff @(posedge clk)
    begin
        pax1_reg <= ax;
        pay1_reg <= ay;
        rbx_reg  <= RW'(bx) - RW'(ax);
        rby_reg  <= RW'(by_coord) - RW'(ay);
        rcx_reg  <= RW'(cx) - RW'(ax);
        rcy_reg  <= RW'(cy) - RW'(ay);
    end

    // stage 2: products
    logic v2_reg;
    logic signed [CW-1:0] pax2_reg, pay2_reg;
    logic signed [RW-1:0] rbx2_reg, rby2_reg, rcx2_reg, rcy2_reg;
    logic signed [PW-1:0] p_bxcy_reg, p_bycx_reg, p_bxbx_reg, p_byby_reg,
                          p_cxcx_reg, p_cycy_reg;
    always_ff @(posedge clk)
    begin
        pax2_reg <= pax1_reg;
        pay2_reg <= pay1_reg;
        rbx2_reg <= rbx_reg;
        rby2_reg <= rby_reg;
        rcx2_reg <= rcx_reg;
        rcy2_reg <= rcy_reg;
        p_bxcy_reg <= rbx_reg * rcy_reg;
        p_bycx_reg <= rby_reg * rcx_reg;
        p_bxbx_reg <= rbx_reg * rbx_reg;
        p_byby_reg <= rby_reg * rby_reg;
        p_cxcx_reg <= rcx_reg * rcx_reg;
        p_cycy_reg <= rcy_reg * rcy_reg;
    end

    // stage 3: determinant and squared sums
    logic v3_reg;
    logic signed [CW-1:0] pax3_reg, pay3_reg;
    logic signed [RW-1:0] rbx3_reg, rby3_reg, rcx3_reg, rcy3_reg;
    logic signed [DW-1:0] det_reg;
    logic signed [SW-1:0] sb_reg, sc_reg;
    always_ff @(posedge clk)
    begin
        pax3_reg <= pax2_reg;
        pay3_reg <= pay2_reg;
        rbx3_reg <= rbx2_reg;
        rby3_reg <= rby2_reg;
        rcx3_reg <= rcx2_reg;
        rcy3_reg <= rcy2_reg;
        det_reg  <= (DW'(p_bxcy_reg) - DW'(p_bycx_reg)) <<< 1;
        sb_reg   <= SW'(p_bxbx_reg) + SW'(p_byby_reg);
        sc_reg   <= SW'(p_cxcx_reg) + SW'(p_cycy_reg);
    end

    // stage 4: four products for the numerators
    logic v4_reg;
    logic signed [CW-1:0] pax4_reg, pay4_reg;
    logic signed [DW-1:0] det4_reg;
    logic signed [NW-1:0] m1_reg, m2_reg, m3_reg, m4_reg;
    always_ff @(posedge clk)
    begin
        pax4_reg <= pax3_reg;
        pay4_reg <= pay3_reg;
        det4_reg <= det_reg;
        m1_reg   <= NW'(rcy3_reg) * NW'(sb_reg);
        m2_reg   <= NW'(rby3_reg) * NW'(sc_reg);
        m3_reg   <= NW'(rbx3_reg) * NW'(sc_reg);
        m4_reg   <= NW'(rcx3_reg) * NW'(sb_reg);
    end

    // front valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start & ~busy;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    // numerators to magnitudes, load the division chain
    logic signed [NW-1:0] nx, ny;
    logic [DW-1:0]        dmag;
    cc_pkg::div_t         div_chain [0:NW];
    always_comb
    begin
        nx   = m1_reg - m2_reg;
        ny   = m3_reg - m4_reg;
        dmag = det4_reg[DW-1] ? DW'(-det4_reg) : DW'(det4_reg);
        div_chain[0].ctx.vld   = v4_reg;
        div_chain[0].ctx.degen = (det4_reg == '0);
        div_chain[0].ctx.pax   = pax4_reg;
        div_chain[0].ctx.pay   = pay4_reg;
        div_chain[0].neg_x = nx[NW-1] ^ det4_reg[DW-1];
        div_chain[0].neg_y = ny[NW-1] ^ det4_reg[DW-1];
        div_chain[0].num_x = nx[NW-1] ? NW'(-nx) : NW'(nx);
        div_chain[0].num_y = ny[NW-1] ? NW'(-ny) : NW'(ny);
        div_chain[0].den   = (det4_reg == '0) ? DW'(1) : dmag;
        div_chain[0].rem_x = '0;
        div_chain[0].rem_y = '0;
        div_chain[0].q_x   = '0;
        div_chain[0].q_y   = '0;
    end

    // chain of division cells, one quotient bit each
    for (genvar i = 0; i < NW; i++)
    begin : g_div
        cc_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (div_chain[i]),
            .dout (div_chain[i+1])
        );
    end

    // sign fixup, saturation, clamp offsets for the root
    cc_pkg::div_t         df;
    logic signed [NW+1:0] ox, oy, cxv, cyv;
    logic signed [NW+1:0] smax, smin, umax;
    logic                 ovf_c, big_c;
    logic [OW-1:0]        ax_abs, ay_abs;
    logic signed [OW-1:0] ox_s, oy_s;
    always_comb
    begin
        df   = div_chain[NW];
        smax = (NW+2)'((1 << (CW - 1)) - 1);
        smin = -smax - (NW+2)'(1);
        umax = (NW+2)'((1 << CW) - 1);
        ox   = df.neg_x ? -$signed({2'b00, df.q_x}) : $signed({2'b00, df.q_x});
        oy   = df.neg_y ? -$signed({2'b00, df.q_y}) : $signed({2'b00, df.q_y});
        cxv  = ox + (NW+2)'(df.ctx.pax);
        cyv  = oy + (NW+2)'(df.ctx.pay);
        ovf_c = 1'b0;
        if (cxv > smax)
        begin
            cxv = smax;
            ovf_c = 1'b1;
        end
        else if (cxv < smin)
        begin
            cxv = smin;
            ovf_c = 1'b1;
        end
        if (cyv > smax)
        begin
            cyv = smax;
            ovf_c = 1'b1;
        end
        else if (cyv < smin)
        begin
            cyv = smin;
            ovf_c = 1'b1;
        end
        big_c  = (ox > umax) || (ox < -umax) || (oy > umax) || (oy < -umax);
        ox_s   = ox[OW-1:0];
        oy_s   = oy[OW-1:0];
        ax_abs = ox_s[OW-1] ? OW'(-ox_s) : OW'(ox_s);
        ay_abs = oy_s[OW-1] ? OW'(-oy_s) : OW'(oy_s);
    end

    // fixup register feeds the squaring stage
    logic                 vf_reg;
    cc_pkg::ctx_t         ctxf_reg;
    logic signed [CW-1:0] cxf_reg, cyf_reg;
    logic                 ovff_reg, bigf_reg;
    logic [OW-1:0]        axf_reg, ayf_reg;
    always_ff @(posedge clk)
    begin
        ctxf_reg <= df.ctx;
        cxf_reg  <= cxv[CW-1:0];
        cyf_reg  <= cyv[CW-1:0];
        ovff_reg <= ovf_c;
        bigf_reg <= big_c;
        axf_reg  <= big_c ? '0 : ax_abs;
        ayf_reg  <= big_c ? '0 : ay_abs;
    end

    // squared radius register
    logic            vs_reg;
    cc_pkg::sqr_t    sq_chain [0:NR];
    cc_pkg::ctx_t    ctxs_reg;
    logic signed [CW-1:0] cxs_reg, cys_reg;
    logic            ovfs_reg, bigs_reg;
    logic [RSW-1:0]  rsq_reg;
    always_ff @(posedge clk)
    begin
        ctxs_reg <= ctxf_reg;
        cxs_reg  <= cxf_reg;
        cys_reg  <= cyf_reg;
        ovfs_reg <= ovff_reg;
        bigs_reg <= bigf_reg;
        rsq_reg  <= axf_reg * axf_reg + ayf_reg * ayf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vf_reg <= 1'b0;
            vs_reg <= 1'b0;
        end
        else
        begin
            vf_reg <= df.ctx.vld;
            vs_reg <= vf_reg;
        end
    end

    // load the root chain
    always_comb
    begin
        sq_chain[0].ctx     = ctxs_reg;
        sq_chain[0].ctx.vld = vs_reg;
        sq_chain[0].cxs     = cxs_reg;
        sq_chain[0].cys     = cys_reg;
        sq_chain[0].ovf     = ovfs_reg;
        sq_chain[0].big     = bigs_reg;
        sq_chain[0].n       = rsq_reg;
        sq_chain[0].rem     = '0;
        sq_chain[0].root    = '0;
    end

    // chain of root cells, one root bit each
    for (genvar j = 0; j < NR; j++)
    begin : g_sqrt
        cc_sqrt_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (sq_chain[j]),
            .dout (sq_chain[j+1])
        );
    end

    // final saturation and output register
    cc_pkg::sqr_t so;
    logic [CW-1:0] rad_c;
    logic          ovf_o;
    always_comb
    begin
        so    = sq_chain[NR];
        ovf_o = so.ovf;
        if (so.big || (so.root > NR'((1 << CW) - 1)))
        begin
            rad_c = '1;
            ovf_o = 1'b1;
        end
        else
        begin
            rad_c = so.root[CW-1:0];
        end
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= so.ctx.vld;
    end

    always_ff @(posedge clk)
    begin
        center_x   <= so.ctx.degen ? '0 : so.cxs;
        center_y   <= so.ctx.degen ? '0 : so.cys;
        radius_out <= so.ctx.degen ? '0 : rad_c;
        degenerate <= so.ctx.degen;
        overflow   <= so.ctx.degen ? 1'b0 : ovf_o;
    end

    assign done = done_reg;

    // checks
    `CC_ASSERT_IMP(a_busy_low, 1'b1, !busy)
    `CC_ASSERT_NEXT(a_front_vld, start, v1_reg)
    `CC_ASSERT_IMP(a_degen_clean, done && degenerate, !overflow && radius_out == '0)
    `CC_ASSERT_NEXT(a_out_vld, so.ctx.vld, done)

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the circumcircle pipeline: a queue-fed driver
// sends point triples, a monitor compares every result against an
// in-bench integer model of the center, radius and flags
// ----------------------------------------------------------------------------
module tb_top;

    localparam int         W          = 16;
    localparam longint     SMAX       = (64'sd1 <<< (W - 1)) - 1;
    localparam longint     SMIN       = -SMAX - 1;
    localparam longint     UMAX       = (64'sd1 <<< W) - 1;
    localparam int         DRAIN      = 120;
    localparam int         STALL_MAX  = 5000;
    localparam int         RAND_ITEMS = 750;

    typedef struct {
        logic signed [W-1:0] ax, ay, bx, by, cx, cy;
    } triple_t;

    typedef struct {
        logic signed [W-1:0] cx, cy;
        logic [W-1:0]        rad;
        logic                degen, ovf;
    } circle_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic signed [W-1:0] ax, ay, bx, by_coord, cx, cy;
    logic done;
    logic signed [W-1:0] center_x, center_y;
    logic [W-1:0]        radius_out;
    logic                degenerate, overflow;

    triple_t pending_reqs[$];
    circle_t expected_circles[$];
    int      fail_cnt = 0;
    int      sent_cnt = 0;
    int      idle_pct = 0;
    int      quiet_cycles = 0;
    bit      draining = 0;

    circumcircle_from_three_points dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .ax(ax), .ay(ay), .bx(bx), .by_coord(by_coord), .cx(cx), .cy(cy),
        .done(done), .center_x(center_x), .center_y(center_y),
        .radius_out(radius_out), .degenerate(degenerate), .overflow(overflow)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // floor square root, bit pair at a time
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= r + b)
            begin
                n = n - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // expected circle for one triple
    function automatic circle_t predict_circle(triple_t t);
        circle_t c;
        longint  pax, pay, ubx, uby, ucx, ucy, det, sb, sc, ox, oy, vx, vy;
        pax = t.ax;
        pay = t.ay;
        ubx = longint'(t.bx) - pax;
        uby = longint'(t.by) - pay;
        ucx = longint'(t.cx) - pax;
        ucy = longint'(t.cy) - pay;
        det = 2 * (ubx * ucy - uby * ucx);
        c = '{cx: '0, cy: '0, rad: '0, degen: 1'b0, ovf: 1'b0};
        // collinear points
        if (det == 0)
        begin
            c.degen = 1'b1;
            return c;
        end
        sb = ubx * ubx + uby * uby;
        sc = ucx * ucx + ucy * ucy;
        ox = (ucy * sb - uby * sc) / det;
        oy = (ubx * sc - ucx * sb) / det;
        vx = ox + pax;
        vy = oy + pay;
        // saturate center
        if (vx > SMAX) begin vx = SMAX; c.ovf = 1'b1; end
        if (vx < SMIN) begin vx = SMIN; c.ovf = 1'b1; end
        if (vy > SMAX) begin vy = SMAX; c.ovf = 1'b1; end
        if (vy < SMIN) begin vy = SMIN; c.ovf = 1'b1; end
        c.cx = vx[W-1:0];
        c.cy = vy[W-1:0];
        // radius, clamped
        if (ox > UMAX || ox < -UMAX || oy > UMAX || oy < -UMAX)
        begin
            c.rad = UMAX[W-1:0];
            c.ovf = 1'b1;
        end
        else
        begin
            vx = longint'(floor_root(longint'(ox * ox + oy * oy)));
            if (vx > UMAX)
            begin
                vx = UMAX;
                c.ovf = 1'b1;
            end
            c.rad = vx[W-1:0];
        end
        return c;
    endfunction

    function automatic triple_t mk(int a0, int a1, int b0, int b1, int c0, int c1);
        triple_t t;
        t.ax = a0[W-1:0]; t.ay = a1[W-1:0];
        t.bx = b0[W-1:0]; t.by = b1[W-1:0];
        t.cx = c0[W-1:0]; t.cy = c1[W-1:0];
        return t;
    endfunction

    function automatic logic signed [W-1:0] rand_coord();
        return W'($urandom());
    endfunction

    // a coordinate near a base point
    function automatic logic signed [W-1:0] near(logic signed [W-1:0] base, int span);
        int v;
        v = int'(base) + $urandom_range(2 * span) - span;
        return v[W-1:0];
    endfunction

    // fill the request queue
    initial
    begin
        triple_t t;
        int      k, dx, dy, m;
        // directed: zero, right triangle, extremes, collinear, coincident, huge circle
        pending_reqs.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(mk(0, 0, 256, 0, 0, 256));
        pending_reqs.push_back(mk(-256, 0, 256, 0, 0, 256));
        pending_reqs.push_back(mk(-32768, -32768, 32767, -32768, -32768, 32767));
        pending_reqs.push_back(mk(32767, 32767, -32768, 32767, 32767, -32768));
        pending_reqs.push_back(mk(-32768, -32768, 32767, 32767, -32768, 32767));
        pending_reqs.push_back(mk(-32768, 32767, 32767, -32768, 32767, 32767));
        pending_reqs.push_back(mk(-32768, -32768, 0, 0, 32767, 32767));
        pending_reqs.push_back(mk(100, 200, 300, 400, 500, 600));
        pending_reqs.push_back(mk(5, 5, 5, 5, 1000, -1000));
        pending_reqs.push_back(mk(5, 5, 5, 5, 5, 5));
        pending_reqs.push_back(mk(0, 0, 1, 0, 0, 1));
        pending_reqs.push_back(mk(-32768, 0, 32767, 0, 0, 1));
        pending_reqs.push_back(mk(-32768, 0, 32767, 1, 0, 0));
        pending_reqs.push_back(mk(0, 0, 32767, 1, -32768, 0));
        pending_reqs.push_back(mk(30000, 30000, 32767, 32767, 32000, 32767));
        pending_reqs.push_back(mk(-30000, -30000, -32768, -32768, -32000, -32768));
        pending_reqs.push_back(mk(0, 0, 32767, 32767, 0, 32767));
        pending_reqs.push_back(mk(-1, -1, 1, 1, -1, 1));
        pending_reqs.push_back(mk(0, -32768, 0, 32767, 32767, 0));
        // random: well spread, local, nearly collinear and coincident
        for (int i = 0; i < RAND_ITEMS; i++)
        begin
            k = $urandom_range(99);
            if (k < 35)
                t = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
            else if (k < 65)
            begin
                t.ax = rand_coord();
                t.ay = rand_coord();
                t.bx = near(t.ax, 2000);
                t.by = near(t.ay, 2000);
                t.cx = near(t.ax, 2000);
                t.cy = near(t.ay, 2000);
            end
            else if (k < 90)
            begin
                // c on or next to the line through a and b
                dx = $urandom_range(600) - 300;
                dy = $urandom_range(600) - 300;
                m = $urandom_range(8) - 4;
                t.ax = near(16'sd0, 20000);
                t.ay = near(16'sd0, 20000);
                t.bx = t.ax + dx[W-1:0];
                t.by = t.ay + dy[W-1:0];
                t.cx = near(W'(t.ax + m * dx), ($urandom_range(3) == 0) ? 0 : 2);
                t.cy = near(W'(t.ay + m * dy), ($urandom_range(3) == 0) ? 0 : 2);
            end
            else
            begin
                // coincident points
                t = mk(rand_coord(), rand_coord(), rand_coord(), rand_coord(),
                       rand_coord(), rand_coord());
                if ($urandom_range(1)) begin t.bx = t.ax; t.by = t.ay; end
                else begin t.cx = t.bx; t.cy = t.by; end
            end
            pending_reqs.push_back(t);
        end
    end

    // reset and end of run
    initial
    begin
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_reqs.size() == 0 && !start);
        wait (expected_circles.size() == 0);
        draining = 1'b1;
        repeat (DRAIN) @(posedge clk);
        if (fail_cnt == 0 && expected_circles.size() == 0)
            $display("** circumcircle_from_three_points: PASSED **");
        else
            $display("** circumcircle_from_three_points: FAILED **");
        $finish;
    end

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            ax <= '0; ay <= '0; bx <= '0; by_coord <= '0; cx <= '0; cy <= '0;
        end
        else
        begin
            if (start && !busy)
            begin
                expected_circles.push_back(predict_circle(pending_reqs.pop_front()));
                sent_cnt++;
            end
            // idling phases by progress: none, sender, receiver (cannot stall), both
            case ((sent_cnt / 110) % 4)
                0: idle_pct = 0;
                1: idle_pct = 61;
                2: idle_pct = 0;
                default: idle_pct = 16;
            endcase
            if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct)
            begin
                start <= 1'b1;
                ax <= pending_reqs[0].ax;
                ay <= pending_reqs[0].ay;
                bx <= pending_reqs[0].bx;
                by_coord <= pending_reqs[0].by;
                cx <= pending_reqs[0].cx;
                cy <= pending_reqs[0].cy;
            end
            else
                start <= 1'b0;
        end
    end

    task automatic check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, want, got);
            fail_cnt++;
        end
    endtask

    // result monitor
    always @(posedge clk)
    begin
        circle_t e;
        if (rst_n && done)
        begin
            if (expected_circles.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual cx %0d cy %0d r %0d",
                         $realtime, center_x, center_y, radius_out);
                fail_cnt++;
            end
            else
            begin
                e = expected_circles.pop_front();
                check_field("center_x", e.cx, center_x);
                check_field("center_y", e.cy, center_y);
                check_field("radius_out", e.rad, radius_out);
                check_field("degenerate", e.degen, degenerate);
                check_field("overflow", e.ovf, overflow);
            end
        end
    end

    // watchdog on cycles with no request or result moving
    always @(posedge clk)
    begin
        if (!rst_n || draining || (start && !busy) || done)
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX)
        begin
            $display("** circumcircle_from_three_points: FAILED **");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/cc_pkg.sv
hw/rtl/cc_div_cell.sv
hw/rtl/cc_sqrt_cell.sv
hw/rtl/circumcircle_from_three_points.sv
bench/tb_top.sv
